// ===== rtl/core/npp_pkg.sv =====
// npp_pkg: types, codes and layout tables of the 9p message parser
// no dependencies; used by every module of the parser
package npp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [4:0]  field_id;
    logic [63:0] out_value;
    logic [3:0]  elem_index;
    logic [2:0]  status;
    logic        out_last;
  } out_word_t;

  typedef struct packed {
    out_word_t res0;
    out_word_t res1;
    logic      two;
  } qent_t;

  localparam int unsigned QDEPTH = 4;

  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_STRLEN  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_BADTYPE  = 3'd2;
  localparam logic [2:0] ST_TOOMANY  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_TOOSMALL = 3'd5;

  localparam logic [5:0] START_BAD   = 6'h3F;
  localparam logic [5:0] START_EMPTY = 6'h3E;

  typedef enum logic [2:0] {
    K_SC, K_USC, K_STR, K_USTR, K_WSTR, K_QID, K_WQID, K_DATA
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [4:0] fld;
    logic [3:0] nbytes;
    logic       fin;
  } opdef_t;

  function automatic opdef_t op_f(input logic [5:0] pc);
    opdef_t r;
    case (pc)
      6'd0:  r = '{K_SC,   5'd0,  4'd4, 1'b0};
      6'd1:  r = '{K_SC,   5'd1,  4'd1, 1'b0};
      6'd2:  r = '{K_SC,   5'd2,  4'd2, 1'b0};
      6'd3:  r = '{K_SC,   5'd3,  4'd4, 1'b0};
      6'd4:  r = '{K_STR,  5'd4,  4'd0, 1'b1};
      6'd5:  r = '{K_SC,   5'd5,  4'd2, 1'b1};
      6'd6:  r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd7:  r = '{K_SC,   5'd6,  4'd4, 1'b0};
      6'd8:  r = '{K_STR,  5'd7,  4'd0, 1'b0};
      6'd9:  r = '{K_STR,  5'd8,  4'd0, 1'b0};
      6'd10: r = '{K_USC,  5'd9,  4'd4, 1'b1};
      6'd11: r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd12: r = '{K_SC,   5'd11, 4'd4, 1'b0};
      6'd13: r = '{K_SC,   5'd12, 4'd2, 1'b0};
      6'd14: r = '{K_WSTR, 5'd13, 4'd0, 1'b1};
      6'd15: r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd16: r = '{K_SC,   5'd14, 4'd1, 1'b1};
      6'd17: r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd18: r = '{K_STR,  5'd15, 4'd0, 1'b0};
      6'd19: r = '{K_SC,   5'd16, 4'd4, 1'b0};
      6'd20: r = '{K_SC,   5'd14, 4'd1, 1'b0};
      6'd21: r = '{K_USTR, 5'd17, 4'd0, 1'b1};
      6'd22: r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd23: r = '{K_SC,   5'd18, 4'd8, 1'b0};
      6'd24: r = '{K_SC,   5'd19, 4'd4, 1'b0};
      6'd25: r = '{K_DATA, 5'd20, 4'd0, 1'b1};
      6'd26: r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd27: r = '{K_SC,   5'd18, 4'd8, 1'b0};
      6'd28: r = '{K_SC,   5'd19, 4'd4, 1'b1};
      6'd29: r = '{K_SC,   5'd10, 4'd4, 1'b0};
      6'd30: r = '{K_SC,   5'd21, 4'd2, 1'b0};
      6'd31: r = '{K_DATA, 5'd22, 4'd0, 1'b1};
      6'd32: r = '{K_SC,   5'd10, 4'd4, 1'b1};
      6'd33: r = '{K_STR,  5'd23, 4'd0, 1'b0};
      6'd34: r = '{K_USC,  5'd24, 4'd4, 1'b1};
      6'd35: r = '{K_QID,  5'd25, 4'd0, 1'b1};
      6'd36: r = '{K_QID,  5'd26, 4'd0, 1'b1};
      6'd37: r = '{K_SC,   5'd27, 4'd2, 1'b0};
      6'd38: r = '{K_WQID, 5'd28, 4'd0, 1'b1};
      6'd39: r = '{K_QID,  5'd26, 4'd0, 1'b0};
      6'd40: r = '{K_SC,   5'd29, 4'd4, 1'b0};
      6'd41: r = '{K_SC,   5'd30, 4'd4, 1'b1};
      6'd42: r = '{K_QID,  5'd26, 4'd0, 1'b0};
      6'd43: r = '{K_SC,   5'd29, 4'd4, 1'b1};
      6'd44: r = '{K_SC,   5'd19, 4'd4, 1'b0};
      6'd45: r = '{K_DATA, 5'd20, 4'd0, 1'b1};
      6'd46: r = '{K_SC,   5'd19, 4'd4, 1'b1};
      6'd47: r = '{K_SC,   5'd21, 4'd2, 1'b0};
      6'd48: r = '{K_DATA, 5'd22, 4'd0, 1'b1};
      default: r = '{K_SC, 5'd0, 4'd0, 1'b1};
    endcase
    return r;
  endfunction

  function automatic logic [5:0] start_of(input logic [7:0] t);
    logic [5:0] s;
    case (t)
      8'd98, 8'd112:           s = 6'd15;
      8'd99:                   s = 6'd39;
      8'd100, 8'd101:          s = 6'd3;
      8'd102:                  s = 6'd7;
      8'd103:                  s = 6'd35;
      8'd104:                  s = 6'd6;
      8'd105:                  s = 6'd36;
      8'd107:                  s = 6'd33;
      8'd108:                  s = 6'd5;
      8'd110:                  s = 6'd11;
      8'd111:                  s = 6'd37;
      8'd113, 8'd115:          s = 6'd42;
      8'd114:                  s = 6'd17;
      8'd116:                  s = 6'd26;
      8'd117:                  s = 6'd44;
      8'd118:                  s = 6'd22;
      8'd119:                  s = 6'd46;
      8'd120, 8'd122, 8'd124:  s = 6'd32;
      8'd125:                  s = 6'd47;
      8'd126:                  s = 6'd29;
      8'd109, 8'd121, 8'd123, 8'd127: s = START_EMPTY;
      default:                 s = START_BAD;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/ninep_message_parser_unit.sv =====
// ninep_message_parser_unit: 9p message parser top level
// a word's results enter the result queue on acceptance, then are registered for output
// throughput: one input word per cycle, input stalls on a full queue; one result word
// per cycle leaves the back end while out_ready_i is high; two results go out as two words
// reset: asynchronous, clears parser state, queue and output valid; unix dialect off
module ninep_message_parser_unit import npp_pkg::*; #(
  parameter int unsigned MAX_WALK_ELEMS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic  unix_q;
  logic  q_full, q_push, q_pop, q_valid;
  qent_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) unix_q <= 1'b0;
    else if (cfg_we_i) unix_q <= cfg_wdata_i;
  end

  npp_front #(.MAX_WALK_ELEMS(MAX_WALK_ELEMS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .dialect_unix_i(unix_q), .q_full_i(q_full), .q_push_o(q_push), .q_ent_o(q_in)
  );

  npp_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .ent_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .ent_o(q_out)
  );

  npp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ent_i(q_out), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .out_word_o
  );

  a_status_fid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.out_kind == KIND_STATUS |-> out_word_o.field_id == 5'd0)
    else $error("status word with field id");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.out_kind == KIND_STATUS && out_word_o.status != ST_OK
      |-> out_word_o.out_value == 64'd0)
    else $error("failed status carries a value");

  a_elem_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.elem_index != 4'd0
      |-> (out_word_o.field_id == 5'd13 || out_word_o.field_id == 5'd28))
    else $error("element index outside walk fields");

endmodule

// ===== rtl/core/npp_front.sv =====
// npp_front: byte classifier and field state machine of the 9p parser
// depends on npp_pkg; writes at most one queue entry per accepted word
module npp_front import npp_pkg::*; #(
  parameter int unsigned MAX_WALK_ELEMS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     dialect_unix_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output qent_t    q_ent_o
);

  logic [5:0]  step_q, step_d;
  logic [3:0]  bif_q, bif_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] ms_q, ms_d;
  logic [31:0] bc_q, bc_d;
  logic [31:0] pl_q, pl_d;
  logic [7:0]  mt_q, mt_d;
  logic [4:0]  el_q, el_d;
  logic [4:0]  ec_q, ec_d;
  logic        fin_q, fin_d;
  logic        inpay_q, inpay_d;

  logic        fire;
  opdef_t      op, eop;
  logic [7:0]  b;
  logic [31:0] bc_n;
  logic [3:0]  idx;
  logic [4:0]  posn;
  logic [3:0]  pm;
  logic [5:0]  st;
  logic        a_v, s_v, ed_req, adv_req, enter_req, cmpl, skip;
  logic [5:0]  enter_pc;
  logic [2:0]  s_st;
  out_word_t   a_r, s_r;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && !q_full_i;

  always_comb begin
    step_d = step_q; bif_d = bif_q; acc_d = acc_q; ms_d = ms_q; bc_d = bc_q;
    pl_d = pl_q; mt_d = mt_q; el_d = el_q; ec_d = ec_q; fin_d = fin_q;
    inpay_d = inpay_q;
    a_v = 1'b0; s_v = 1'b0; s_st = ST_OK; ed_req = 1'b0; adv_req = 1'b0;
    enter_req = 1'b0; enter_pc = '0; cmpl = 1'b0; skip = 1'b0;
    a_r = '0;
    op   = op_f(step_q);
    eop  = op;
    b    = in_word_i.in_byte;
    bc_n = bc_q + 32'd1;
    idx  = (op.kind == K_WSTR || op.kind == K_WQID) ? ec_q[3:0] : 4'd0;
    posn = {1'b0, bif_q} + 5'd1;
    pm   = '0;
    st   = start_of(mt_q);
    if (fire && !fin_q) begin
      bc_d = bc_n;
      case (op.kind)
        K_SC, K_USC: begin
          if (bif_q == 4'd0) acc_d = {56'd0, b};
          else acc_d = acc_q | ({56'd0, b} << {bif_q[2:0], 3'b000});
          bif_d = posn[3:0];
          if (posn >= {1'b0, op.nbytes}) begin
            bif_d = '0;
            a_v = 1'b1;
            a_r = '{KIND_SCALAR, op.fld, acc_d, 4'd0, ST_OK, 1'b0};
            if (step_q == 6'd0) begin
              ms_d = acc_d[31:0];
              if (acc_d[31:0] < 32'd7) begin
                s_v = 1'b1; s_st = ST_TOOSMALL;
              end else step_d = 6'd1;
            end else if (step_q == 6'd1) begin
              mt_d = acc_d[7:0];
              if (start_of(acc_d[7:0]) == START_BAD) begin
                s_v = 1'b1; s_st = ST_BADTYPE;
              end else step_d = 6'd2;
            end else if (step_q == 6'd2) begin
              if (st == START_EMPTY) cmpl = 1'b1;
              else if (st == START_BAD) begin
                s_v = 1'b1; s_st = ST_BADTYPE;
              end else begin
                enter_req = 1'b1; enter_pc = st;
              end
            end else adv_req = 1'b1;
          end
        end
        K_STR, K_USTR, K_WSTR: begin
          if (inpay_q) begin
            a_v = 1'b1;
            a_r = '{KIND_PAYLOAD, op.fld, {56'd0, b}, idx, ST_OK, 1'b0};
            pl_d = pl_q - 32'd1;
            if (pl_q == 32'd1) ed_req = 1'b1;
          end else begin
            if (bif_q == 4'd0) begin
              acc_d = {56'd0, b};
              bif_d = 4'd1;
            end else begin
              acc_d = acc_q | {48'd0, b, 8'd0};
              bif_d = '0;
              a_v = 1'b1;
              a_r = '{KIND_STRLEN, op.fld, acc_d, idx, ST_OK, 1'b0};
              pl_d = acc_d[31:0];
              if (acc_d == 64'd0) ed_req = 1'b1;
              else inpay_d = 1'b1;
            end
          end
        end
        K_QID, K_WQID: begin
          if (bif_q == 4'd0) begin
            a_v = 1'b1;
            a_r = '{KIND_SCALAR, op.fld, {56'd0, b}, idx, ST_OK, 1'b0};
          end else if (bif_q <= 4'd4) begin
            pm = bif_q - 4'd1;
            if (bif_q == 4'd1) acc_d = {56'd0, b};
            else acc_d = acc_q | ({56'd0, b} << {pm[1:0], 3'b000});
            if (bif_q == 4'd4) begin
              a_v = 1'b1;
              a_r = '{KIND_SCALAR, op.fld, acc_d, idx, ST_OK, 1'b0};
            end
          end else begin
            pm = bif_q - 4'd5;
            if (bif_q == 4'd5) acc_d = {56'd0, b};
            else acc_d = acc_q | ({56'd0, b} << {pm[2:0], 3'b000});
            if (bif_q == 4'd12) begin
              a_v = 1'b1;
              a_r = '{KIND_SCALAR, op.fld, acc_d, idx, ST_OK, 1'b0};
            end
          end
          bif_d = posn[3:0];
          if (posn >= 5'd13) ed_req = 1'b1;
        end
        default: begin
          a_v = 1'b1;
          a_r = '{KIND_PAYLOAD, op.fld, {56'd0, b}, 4'd0, ST_OK, 1'b0};
          pl_d = pl_q - 32'd1;
          if (pl_q == 32'd1) adv_req = 1'b1;
        end
      endcase
      // element finished
      if (ed_req) begin
        bif_d = '0;
        inpay_d = 1'b0;
        if (op.kind == K_WSTR || op.kind == K_WQID) begin
          ec_d = ec_q + 5'd1;
          el_d = (el_q != 5'd0) ? el_q - 5'd1 : el_q;
          if (el_d == 5'd0) adv_req = 1'b1;
        end else adv_req = 1'b1;
      end
      if (adv_req) begin
        if (op.fin) cmpl = 1'b1;
        else begin
          enter_req = 1'b1; enter_pc = step_q + 6'd1;
        end
      end
      if (enter_req) begin
        eop = op_f(enter_pc);
        step_d = enter_pc;
        bif_d = '0;
        inpay_d = 1'b0;
        if ((eop.kind == K_USC || eop.kind == K_USTR) && !dialect_unix_i) skip = 1'b1;
        else if (eop.kind == K_DATA) begin
          pl_d = acc_d[31:0];
          skip = (acc_d[31:0] == 32'd0);
        end else if (eop.kind == K_WSTR || eop.kind == K_WQID) begin
          if (acc_d > 64'(MAX_WALK_ELEMS)) begin
            s_v = 1'b1; s_st = ST_TOOMANY;
          end else begin
            el_d = acc_d[4:0];
            ec_d = '0;
            skip = (acc_d[4:0] == 5'd0);
          end
        end
        if (skip) cmpl = 1'b1;
      end
      if (cmpl) begin
        s_v = 1'b1;
        s_st = (bc_n == ms_q) ? ST_OK : ST_MISMATCH;
      end
      if (s_v) fin_d = 1'b1;
      else if (in_word_i.in_last) begin
        s_v = 1'b1; s_st = ST_TRUNC;
      end
    end
    s_r = '{KIND_STATUS, 5'd0, (s_st == ST_OK) ? {32'd0, ms_q} : 64'd0, 4'd0, s_st, 1'b1};
    if (fire && in_word_i.in_last) begin
      step_d = '0; bif_d = '0; acc_d = '0; ms_d = '0; bc_d = '0; pl_d = '0;
      mt_d = '0; el_d = '0; ec_d = '0; fin_d = 1'b0; inpay_d = 1'b0;
    end
  end

  always_comb begin
    q_push_o = a_v || s_v;
    q_ent_o  = '0;
    if (a_v) begin
      q_ent_o.res0 = a_r;
      q_ent_o.res0.out_last = !s_v;
      q_ent_o.res1 = s_r;
      q_ent_o.two  = s_v;
    end else begin
      q_ent_o.res0 = s_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0; bif_q <= '0; acc_q <= '0; ms_q <= '0; bc_q <= '0;
      pl_q <= '0; mt_q <= '0; el_q <= '0; ec_q <= '0; fin_q <= 1'b0;
      inpay_q <= 1'b0;
    end else if (fire) begin
      step_q <= step_d; bif_q <= bif_d; acc_q <= acc_d; ms_q <= ms_d; bc_q <= bc_d;
      pl_q <= pl_d; mt_q <= mt_d; el_q <= el_d; ec_q <= ec_d; fin_q <= fin_d;
      inpay_q <= inpay_d;
    end
  end

endmodule

// ===== rtl/core/npp_queue.sv =====
// npp_queue: short result queue between parser front and output back end
// depends on npp_pkg for the entry type and depth
module npp_queue import npp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t ent_o
);

  localparam int unsigned AW = $clog2(QDEPTH);

  qent_t          mem_q [QDEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [AW:0]    cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign ent_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + AW'(1);
      if (do_pop) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/npp_back.sv =====
// npp_back: splits queue entries into single result words on the output
// depends on npp_pkg; holds the output register
module npp_back import npp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  qent_t     q_ent_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      ov_q, ov_d, half_q, half_d, load;
  out_word_t ow_q, ow_d;

  always_comb begin
    load = !ov_q || out_ready_i;
    ov_d = ov_q; half_d = half_q; ow_d = ow_q; q_pop_o = 1'b0;
    if (load) begin
      ov_d = q_valid_i;
      if (q_valid_i) begin
        ow_d = half_q ? q_ent_i.res1 : q_ent_i.res0;
        if (q_ent_i.two && !half_q) half_d = 1'b1;
        else begin
          half_d = 1'b0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; half_q <= 1'b0;
    end else begin
      ov_q <= ov_d; half_q <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ow_q <= ow_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for ninep_message_parser_unit
// drives 9p message bytes, predicts each result word and compares in order
// depends on npp_pkg and the parser top level
module tb;
  import npp_pkg::*;

  typedef enum logic [2:0] {
    OP_SC, OP_USC, OP_STR, OP_USTR, OP_WSTR, OP_QID, OP_WQID, OP_DATA
  } layout_e;

  typedef struct packed {
    layout_e    kind;
    logic [4:0] fld;
    logic [3:0] nb;
    logic       fin;
  } layout_t;

  localparam int NSTEPS = 49;
  localparam logic [5:0] STEP_BAD = 6'h3F;
  localparam logic [5:0] STEP_EMPTY = 6'h3E;
  localparam int WATCH_LIMIT = 2000;
  localparam int MAX_ELEMS = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;

  ninep_message_parser_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  layout_t steps [NSTEPS];
  in_word_t byte_q[$];
  out_word_t want_q[$];
  int errors = 0;
  int idle_send = 0, idle_recv = 0;
  bit calm = 1'b0;
  bit feed_on = 1'b0;
  int quiet = 0;

  // parser model state
  bit unix_on;
  logic [5:0] pstep;
  logic [3:0] bif;
  logic [63:0] acc;
  logic [31:0] msize, consumed, pleft;
  logic [7:0] mtype;
  logic [4:0] eleft;
  bit done;
  logic [3:0] ecount;
  bit in_pay;
  out_word_t res_buf[2];
  int nres;

  function automatic layout_t mk(layout_e k, int f, int n, bit fin);
    layout_t l;
    l.kind = k; l.fld = f[4:0]; l.nb = n[3:0]; l.fin = fin;
    return l;
  endfunction

  initial begin
    steps[0] = mk(OP_SC, 0, 4, 0);   steps[1] = mk(OP_SC, 1, 1, 0);
    steps[2] = mk(OP_SC, 2, 2, 0);   steps[3] = mk(OP_SC, 3, 4, 0);
    steps[4] = mk(OP_STR, 4, 0, 1);  steps[5] = mk(OP_SC, 5, 2, 1);
    steps[6] = mk(OP_SC, 10, 4, 0);  steps[7] = mk(OP_SC, 6, 4, 0);
    steps[8] = mk(OP_STR, 7, 0, 0);  steps[9] = mk(OP_STR, 8, 0, 0);
    steps[10] = mk(OP_USC, 9, 4, 1); steps[11] = mk(OP_SC, 10, 4, 0);
    steps[12] = mk(OP_SC, 11, 4, 0); steps[13] = mk(OP_SC, 12, 2, 0);
    steps[14] = mk(OP_WSTR, 13, 0, 1); steps[15] = mk(OP_SC, 10, 4, 0);
    steps[16] = mk(OP_SC, 14, 1, 1); steps[17] = mk(OP_SC, 10, 4, 0);
    steps[18] = mk(OP_STR, 15, 0, 0); steps[19] = mk(OP_SC, 16, 4, 0);
    steps[20] = mk(OP_SC, 14, 1, 0); steps[21] = mk(OP_USTR, 17, 0, 1);
    steps[22] = mk(OP_SC, 10, 4, 0); steps[23] = mk(OP_SC, 18, 8, 0);
    steps[24] = mk(OP_SC, 19, 4, 0); steps[25] = mk(OP_DATA, 20, 0, 1);
    steps[26] = mk(OP_SC, 10, 4, 0); steps[27] = mk(OP_SC, 18, 8, 0);
    steps[28] = mk(OP_SC, 19, 4, 1); steps[29] = mk(OP_SC, 10, 4, 0);
    steps[30] = mk(OP_SC, 21, 2, 0); steps[31] = mk(OP_DATA, 22, 0, 1);
    steps[32] = mk(OP_SC, 10, 4, 1); steps[33] = mk(OP_STR, 23, 0, 0);
    steps[34] = mk(OP_USC, 24, 4, 1); steps[35] = mk(OP_QID, 25, 0, 1);
    steps[36] = mk(OP_QID, 26, 0, 1); steps[37] = mk(OP_SC, 27, 2, 0);
    steps[38] = mk(OP_WQID, 28, 0, 1); steps[39] = mk(OP_QID, 26, 0, 0);
    steps[40] = mk(OP_SC, 29, 4, 0); steps[41] = mk(OP_SC, 30, 4, 1);
    steps[42] = mk(OP_QID, 26, 0, 0); steps[43] = mk(OP_SC, 29, 4, 1);
    steps[44] = mk(OP_SC, 19, 4, 0); steps[45] = mk(OP_DATA, 20, 0, 1);
    steps[46] = mk(OP_SC, 19, 4, 1); steps[47] = mk(OP_SC, 21, 2, 0);
    steps[48] = mk(OP_DATA, 22, 0, 1);
  end

  function automatic logic [5:0] layout_start(logic [7:0] t);
    case (t)
      8'd98, 8'd112: return 6'd15;
      8'd99: return 6'd39;
      8'd100, 8'd101: return 6'd3;
      8'd102: return 6'd7;
      8'd103: return 6'd35;
      8'd104: return 6'd6;
      8'd105: return 6'd36;
      8'd107: return 6'd33;
      8'd108: return 6'd5;
      8'd110: return 6'd11;
      8'd111: return 6'd37;
      8'd113, 8'd115: return 6'd42;
      8'd114: return 6'd17;
      8'd116: return 6'd26;
      8'd117: return 6'd44;
      8'd118: return 6'd22;
      8'd119: return 6'd46;
      8'd120, 8'd122, 8'd124: return 6'd32;
      8'd125: return 6'd47;
      8'd126: return 6'd29;
      8'd109, 8'd121, 8'd123, 8'd127: return STEP_EMPTY;
      default: return STEP_BAD;
    endcase
  endfunction

  task automatic emit(logic [1:0] k, logic [4:0] f, logic [63:0] v, logic [3:0] ix,
                      logic [2:0] st);
    if (nres < 2) begin
      res_buf[nres] = '{out_kind: k, field_id: f, out_value: v, elem_index: ix,
                        status: st, out_last: 1'b0};
      nres++;
    end
  endtask

  task automatic close_msg(logic [2:0] st);
    emit(KIND_STATUS, 5'd0, st == ST_OK ? 64'(msize) : 64'd0, 4'd0, st);
    done = 1'b1;
  endtask

  task automatic check_end();
    close_msg(consumed == msize ? ST_OK : ST_MISMATCH);
  endtask

  task automatic enter_step(int pc);
    layout_t o;
    bit skip;
    while (pc < NSTEPS) begin
      o = steps[pc];
      skip = 1'b0;
      pstep = pc[5:0]; bif = 0; in_pay = 1'b0;
      if ((o.kind == OP_USC || o.kind == OP_USTR) && !unix_on) skip = 1'b1;
      else if (o.kind == OP_DATA) begin
        pleft = acc[31:0];
        skip = (pleft == 0);
      end else if (o.kind == OP_WSTR || o.kind == OP_WQID) begin
        if (acc > 64'(MAX_ELEMS)) begin
          close_msg(ST_TOOMANY);
          return;
        end
        eleft = acc[4:0];
        ecount = 0;
        skip = (eleft == 0);
      end
      if (!skip) return;
      if (o.fin) begin
        check_end();
        return;
      end
      pc++;
    end
    close_msg(ST_TRUNC);
  endtask

  task automatic next_step();
    if (pstep >= NSTEPS || steps[pstep].fin) check_end();
    else enter_step(int'(pstep) + 1);
  endtask

  task automatic elem_finished(layout_e k);
    bif = 0; in_pay = 1'b0;
    if (k == OP_WSTR || k == OP_WQID) begin
      ecount++;
      if (eleft > 0) eleft--;
      if (eleft == 0) next_step();
    end else next_step();
  endtask

  task automatic scalar_finished(logic [4:0] f);
    logic [5:0] s;
    if (f == 0 && pstep == 0) begin
      msize = acc[31:0];
      if (msize < 7) close_msg(ST_TOOSMALL);
      else pstep = 1;
    end else if (f == 1 && pstep == 1) begin
      mtype = acc[7:0];
      if (layout_start(mtype) == STEP_BAD) close_msg(ST_BADTYPE);
      else pstep = 2;
    end else if (f == 2 && pstep == 2) begin
      s = layout_start(mtype);
      if (s == STEP_EMPTY) check_end();
      else if (s == STEP_BAD) close_msg(ST_BADTYPE);
      else enter_step(s);
    end else next_step();
  endtask

  task automatic take_byte(logic [7:0] b);
    layout_t o;
    int pos;
    logic [3:0] ix;
    pos = bif;
    if (pstep >= NSTEPS) begin
      close_msg(ST_TRUNC);
      return;
    end
    o = steps[pstep];
    ix = (o.kind == OP_WSTR || o.kind == OP_WQID) ? ecount : 4'd0;
    case (o.kind)
      OP_SC, OP_USC: begin
        if (pos == 0) acc = 64'(b);
        else acc |= 64'(b) << ((8 * pos) & 63);
        pos++;
        bif = pos[3:0];
        if (pos >= o.nb) begin
          bif = 0;
          emit(KIND_SCALAR, o.fld, acc, 4'd0, ST_OK);
          scalar_finished(o.fld);
        end
      end
      OP_STR, OP_USTR, OP_WSTR: begin
        if (in_pay) begin
          emit(KIND_PAYLOAD, o.fld, 64'(b), ix, ST_OK);
          pleft--;
          if (pleft == 0) elem_finished(o.kind);
        end else begin
          if (pos == 0) acc = 64'(b);
          else acc |= 64'(b) << 8;
          pos++;
          bif = pos[3:0];
          if (pos >= 2) begin
            bif = 0;
            emit(KIND_STRLEN, o.fld, acc, ix, ST_OK);
            pleft = acc[31:0];
            if (pleft == 0) elem_finished(o.kind);
            else in_pay = 1'b1;
          end
        end
      end
      OP_QID, OP_WQID: begin
        if (pos == 0) emit(KIND_SCALAR, o.fld, 64'(b), ix, ST_OK);
        else if (pos <= 4) begin
          if (pos == 1) acc = 64'(b);
          else acc |= 64'(b) << (8 * (pos - 1));
          if (pos == 4) emit(KIND_SCALAR, o.fld, acc, ix, ST_OK);
        end else begin
          if (pos == 5) acc = 64'(b);
          else acc |= 64'(b) << ((8 * (pos - 5)) & 63);
          if (pos == 12) emit(KIND_SCALAR, o.fld, acc, ix, ST_OK);
        end
        pos++;
        bif = pos[3:0];
        if (pos >= 13) elem_finished(o.kind);
      end
      default: begin
        emit(KIND_PAYLOAD, o.fld, 64'(b), 4'd0, ST_OK);
        pleft--;
        if (pleft == 0) next_step();
      end
    endcase
  endtask

  task automatic clear_parser();
    pstep = 0; bif = 0; acc = 0; msize = 0; consumed = 0; pleft = 0;
    mtype = 0; eleft = 0; done = 1'b0; ecount = 0; in_pay = 1'b0;
  endtask

  task automatic predict_word(in_word_t w);
    nres = 0;
    if (!done) begin
      consumed++;
      take_byte(w.in_byte);
      if (!done && w.in_last) close_msg(ST_TRUNC);
    end
    if (w.in_last) clear_parser();
    if (nres > 0) res_buf[nres - 1].out_last = 1'b1;
    for (int i = 0; i < nres; i++) want_q.push_back(res_buf[i]);
  endtask

  // stimulus building
  task automatic put(int b, bit l = 1'b0);
    byte_q.push_back('{in_byte: b[7:0], in_last: l});
  endtask

  task automatic put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) put(v[8*i +: 8]);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic put_str(int n);
    put_le(n, 2);
    for (int i = 0; i < n; i++) put($urandom_range(0, 255));
  endtask

  task automatic put_qid();
    put($urandom_range(0, 255));
    put_le(rnd64(), 12);
  endtask

  // body of the given type; unix selects the extras
  task automatic put_body(logic [7:0] t, bit ux, int nel);
    int n;
    n = $urandom_range(0, 6);
    case (t)
      8'd100, 8'd101: begin put_le(rnd64(), 4); put_str(n); end
      8'd108: put_le(rnd64(), 2);
      8'd104, 8'd102: begin
        if (t == 8'd104) put_le(rnd64(), 4);
        put_le(rnd64(), 4); put_str(n); put_str($urandom_range(0, 4));
        if (ux) put_le(rnd64(), 4);
      end
      8'd110: begin
        put_le(rnd64(), 8); put_le(nel, 2);
        for (int i = 0; i < nel && i < 16; i++) put_str($urandom_range(0, 3));
      end
      8'd98, 8'd112: begin put_le(rnd64(), 4); put($urandom_range(0, 255)); end
      8'd114: begin
        put_le(rnd64(), 4); put_str(n); put_le(rnd64(), 5);
        if (ux) put_str($urandom_range(0, 4));
      end
      8'd118: begin put_le(rnd64(), 12); put_le(n, 4); repeat (n) put($urandom_range(0, 255)); end
      8'd116: put_le(rnd64(), 16);
      8'd126: begin put_le(rnd64(), 4); put_le(n, 2); repeat (n) put($urandom_range(0, 255)); end
      8'd120, 8'd122, 8'd124, 8'd119: put_le(rnd64(), 4);
      8'd107: begin put_str(n); if (ux) put_le(rnd64(), 4); end
      8'd103, 8'd105: put_qid();
      8'd111: begin
        put_le(nel, 2);
        for (int i = 0; i < nel && i < 16; i++) put_qid();
      end
      8'd99: begin put_qid(); put_le(rnd64(), 8); end
      8'd113, 8'd115: begin put_qid(); put_le(rnd64(), 4); end
      8'd117, 8'd125: begin
        put_le(n, t == 8'd117 ? 4 : 2); repeat (n) put($urandom_range(0, 255));
      end
      default: ;
    endcase
  endtask

  // one message; mode 0 well formed, 1 wrong size, 2 cut to a random length, 3 trailing junk
  task automatic put_msg(logic [7:0] t, bit ux, int nel, int mode);
    in_word_t body[$];
    int sz, cut;
    body = byte_q;
    byte_q.delete();
    put(t); put_le($urandom(), 2);
    put_body(t, ux, nel);
    sz = byte_q.size() + 4;
    if (mode == 1) sz = sz + $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
    byte_q.push_front('{in_byte: sz[31:24], in_last: 1'b0});
    byte_q.push_front('{in_byte: sz[23:16], in_last: 1'b0});
    byte_q.push_front('{in_byte: sz[15:8], in_last: 1'b0});
    byte_q.push_front('{in_byte: sz[7:0], in_last: 1'b0});
    if (mode == 2) begin
      cut = $urandom_range(1, byte_q.size());
      while (byte_q.size() > cut) void'(byte_q.pop_back());
    end else if (mode == 3) repeat ($urandom_range(1, 4)) put($urandom_range(0, 255));
    byte_q[byte_q.size() - 1].in_last = 1'b1;
    byte_q = {body, byte_q};
  endtask

  localparam logic [7:0] TYPES [28] = '{
    8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108,
    8'd109, 8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117,
    8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd124, 8'd125, 8'd126, 8'd127
  };

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_word(in_word_i);
      void'(byte_q.pop_front());
    end
    if (idle_send > 0) begin
      idle_send <= idle_send - 1;
      if (!(in_valid_i && !in_ready_o)) in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (!calm && $urandom_range(0, 15) == 0) begin
        idle_send <= $urandom_range(1, 10);
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > 0 && rst_ni && feed_on) begin
        in_valid_i <= 1'b1;
        in_word_i <= byte_q[0];
      end else in_valid_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t w;
    if (out_valid_o && out_ready_i) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, out_word_o);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (w !== out_word_o) begin
          $display("%0t: mismatch expected %p actual %p", $time, w, out_word_o);
          errors++;
        end
      end
    end
    if (idle_recv > 0) begin
      idle_recv <= idle_recv - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      idle_recv <= $urandom_range(1, 10);
      out_ready_i <= 1'b0;
    end else out_ready_i <= 1'b1;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !feed_on) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic drain();
    while (byte_q.size() > 0 || in_valid_i || want_q.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_dialect(bit v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unix_on = v;
  endtask

  initial begin
    int t;
    unix_on = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed part
    set_dialect(1'b1);
    feed_on = 1'b1;
    put_le(3, 4); put(8'hff, 1'b1);                 // size too small
    put_le(7, 4); put(8'd106); put(8'd0, 1'b1);      // unknown type
    put_msg(8'd110, 1'b1, 17, 0);                    // too many walk names
    put_msg(8'd111, 1'b1, 16, 0);
    put_msg(8'd107, 1'b1, 0, 0);
    put_msg(8'd100, 1'b1, 0, 1);
    put_msg(8'd118, 1'b1, 0, 2);
    put_le(64'hffff_ffff, 4); put(8'd0, 1'b1);
    put_msg(8'd109, 1'b1, 0, 3);
    drain();
    set_dialect(1'b0);
    put_msg(8'd102, 1'b0, 0, 0);
    put_msg(8'd114, 1'b0, 0, 0);
    put_msg(8'd111, 1'b0, 17, 0);
    drain();
    // random part
    for (int ph = 0; ph < 4; ph++) begin
      set_dialect(ph[0]);
      while (byte_q.size() < 150) begin
        t = $urandom_range(0, 9);
        if (t == 0) begin
          repeat ($urandom_range(1, 12)) put($urandom_range(0, 255), $urandom_range(0, 7) == 0);
          put($urandom_range(0, 255), 1'b1);
        end else put_msg(TYPES[$urandom_range(0, 27)], ph[0], $urandom_range(0, 17),
                         t < 7 ? 0 : t - 6);
      end
      if (ph == 3) calm = 1'b1;
      drain();
    end
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/npp_pkg.sv
rtl/core/npp_front.sv
rtl/core/npp_queue.sv
rtl/core/npp_back.sv
rtl/core/ninep_message_parser_unit.sv
tb/sv/tb.sv
